FILE: sv/focus_stack_pixel_fusion_macros.svh
// Assertion macros for the checker file of the fusion block.
`ifndef FOCUS_STACK_PIXEL_FUSION_MACROS_SVH
`define FOCUS_STACK_PIXEL_FUSION_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FSP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fsp_pkg.sv
`timescale 1ns / 1ps

package fsp_pkg;

    // Number of images that take part in the fusion (2 to 4).
    localparam int NUM_IMAGES = 4;
    // Number of images whose fields the input word always carries.
    localparam int PORT_IMAGES = 4;

    localparam int FOCUS_W  = 8;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int PIX_W    = NUM_CH * CH_W;
    localparam int IDX_W    = 2;
    localparam int PROD_W   = 2 * CH_W;

    // Stream word widths.
    localparam int IN_DATA_W  = PORT_IMAGES * (FOCUS_W + PIX_W);
    localparam int OUT_FLD_W  = PIX_W + IDX_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int IMG_CNT_W  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FUSION_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COUNT = 2'd1;
    localparam logic                 MODE_WEIGHTED   = 1'b0;
    localparam logic                 MODE_SELECT     = 1'b1;
    localparam logic [IMG_CNT_W-1:0] IMAGE_COUNT_RST = 3'd4;

    // Arithmetic widths of the weighted mean.
    localparam int TOTAL_MAX = NUM_IMAGES * 255;
    localparam int NUM_MAX   = NUM_IMAGES * 255 * 255;
    localparam int TOTAL_W   = $clog2(TOTAL_MAX + 1);
    localparam int NUM_W     = $clog2(NUM_MAX + 1);
    localparam int DVD_W     = $clog2(2 * NUM_MAX + TOTAL_MAX + 1);

    // Divider layout: one quotient bit per step, a few steps per stage.
    localparam int QUO_W           = CH_W;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;
    localparam int NUM_STAGES      = 2 + DIV_STAGES;

    // One channel of the rounding divider.
    typedef struct packed {
        logic [DVD_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    // All channels of one pixel plus the shifted divisor they share.
    typedef struct packed {
        div_lane_t [NUM_CH-1:0] lane;
        logic [DVD_W-1:0]       dv;
    } div_word_t;

endpackage

FILE: sv/fsp_div_stage.sv
`timescale 1ns / 1ps

// One registered slice of the restoring divider: a few quotient bits for
// every channel, with the divisor halved after each bit.
module fsp_div_stage
(
    input  logic              clk,
    input  logic              en,
    input  fsp_pkg::div_word_t din,
    output fsp_pkg::div_word_t dout
);

    fsp_pkg::div_word_t word_next;
    fsp_pkg::div_word_t word_reg;

    // Compare and subtract, one quotient bit per step.
    always_comb
    begin
        word_next = din;
        for (int s = 0; s < fsp_pkg::STEPS_PER_STAGE; s++)
        begin
            for (int ch = 0; ch < fsp_pkg::NUM_CH; ch++)
            begin
                if (word_next.lane[ch].rem >= word_next.dv)
                begin
                    word_next.lane[ch].rem = word_next.lane[ch].rem - word_next.dv;
                    word_next.lane[ch].quo = {word_next.lane[ch].quo[fsp_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    word_next.lane[ch].quo = {word_next.lane[ch].quo[fsp_pkg::QUO_W-2:0], 1'b0};
                end
            end
            word_next.dv = word_next.dv >> 1;
        end
    end

    // Payload register, loaded whenever the stage may advance.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign dout = word_reg;

endmodule

FILE: sv/focus_stack_pixel_fusion.sv
`timescale 1ns / 1ps

// Focus stack pixel fusion. Each input word carries four 8-bit focus measures
// and four BGR pixels; each output word carries one fused BGR pixel and, in
// select mode, the index of the image that was picked (zero in weighted mode).
// The block takes one word per clock while the output is not stalled. A word
// passes six register stages: one stage forms the focus-weighted products and
// the sharpest-image choice, one stage sums them, and four stages run the
// 8-bit rounding divider at two quotient bits per stage. Backpressure on the
// output stalls only the stages that are full, so bubbles in the pipeline
// still accept new words. Registers are written through the configuration
// channel, which is always ready, and should be changed only while no words
// are in flight.
module focus_stack_pixel_fusion
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: focus_a, focus_b, focus_c, focus_d,
    // pixel_a, pixel_b, pixel_c, pixel_d.
    input  logic [fsp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: fused_blue, fused_green, fused_red, chosen_image,
    // zero padding.
    output logic [fsp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int NSTG = fsp_pkg::NUM_STAGES;

    // Configuration registers.
    logic                           fusion_mode_reg;
    logic [fsp_pkg::IMG_CNT_W-1:0]  image_count_reg;

    // Pipeline control.
    logic [NSTG-1:0]                valid_reg;
    logic [NSTG-1:0]                stage_rdy;

    // Select-mode data that travels beside the arithmetic.
    logic                           mode_reg [NSTG];
    logic [fsp_pkg::PIX_W-1:0]      sel_pix_reg [NSTG];
    logic [fsp_pkg::IDX_W-1:0]      sel_idx_reg [NSTG];

    // Stage 0 signals.
    logic [fsp_pkg::FOCUS_W-1:0]    focus [fsp_pkg::PORT_IMAGES];
    logic [fsp_pkg::PIX_W-1:0]      pix [fsp_pkg::PORT_IMAGES];
    logic [fsp_pkg::TOTAL_W-1:0]    total_next;
    logic [fsp_pkg::TOTAL_W-1:0]    den_next;
    logic [fsp_pkg::PROD_W-1:0]     term_next [fsp_pkg::NUM_IMAGES][fsp_pkg::NUM_CH];
    logic [fsp_pkg::IMG_CNT_W-1:0]  cnt;
    logic [fsp_pkg::FOCUS_W-1:0]    max_focus;
    logic [fsp_pkg::IDX_W-1:0]      best_next;
    logic [fsp_pkg::PROD_W-1:0]     term_reg [fsp_pkg::NUM_IMAGES][fsp_pkg::NUM_CH];
    logic [fsp_pkg::TOTAL_W-1:0]    den_reg;

    // Stage 1 signals and the divider chain.
    fsp_pkg::div_word_t             div_next;
    fsp_pkg::div_word_t             div_word [fsp_pkg::DIV_STAGES+1];
    logic [fsp_pkg::NUM_W-1:0]      num_sum;

    // Configuration writes; an index beyond the list is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fusion_mode_reg <= fsp_pkg::MODE_WEIGHTED;
            image_count_reg <= fsp_pkg::IMAGE_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fsp_pkg::REG_FUSION_MODE: fusion_mode_reg <= cfg_data[0];
                fsp_pkg::REG_IMAGE_COUNT: image_count_reg <= cfg_data[fsp_pkg::IMG_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage may advance when it is empty or the next one advances.
    always_comb
    begin
        stage_rdy[NSTG-1] = !valid_reg[NSTG-1] || m_axis_tready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
    end

    assign s_axis_tready = stage_rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_rdy[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (stage_rdy[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Unpack the input word.
    always_comb
    begin
        for (int k = 0; k < fsp_pkg::PORT_IMAGES; k++)
        begin
            focus[k] = s_axis_tdata[k*fsp_pkg::FOCUS_W +: fsp_pkg::FOCUS_W];
            pix[k]   = s_axis_tdata[fsp_pkg::PORT_IMAGES*fsp_pkg::FOCUS_W
                                    + k*fsp_pkg::PIX_W +: fsp_pkg::PIX_W];
        end
    end

    // Stage 0: total focus, weighted terms and the divisor. With zero total
    // every image gets equal weight, so the terms are the plain channels.
    always_comb
    begin
        total_next = '0;
        for (int k = 0; k < fsp_pkg::NUM_IMAGES; k++)
        begin
            total_next = total_next + fsp_pkg::TOTAL_W'(focus[k]);
        end
        for (int k = 0; k < fsp_pkg::NUM_IMAGES; k++)
        begin
            for (int ch = 0; ch < fsp_pkg::NUM_CH; ch++)
            begin
                if (total_next == '0)
                begin
                    term_next[k][ch] = fsp_pkg::PROD_W'(pix[k][ch*fsp_pkg::CH_W +: fsp_pkg::CH_W]);
                end
                else
                begin
                    term_next[k][ch] =
                        fsp_pkg::PROD_W'(pix[k][ch*fsp_pkg::CH_W +: fsp_pkg::CH_W])
                        * fsp_pkg::PROD_W'(focus[k]);
                end
            end
        end
        den_next = (total_next == '0) ? fsp_pkg::TOTAL_W'(fsp_pkg::NUM_IMAGES) : total_next;
    end

    // Stage 0: sharpest image among the first image_count, first maximum wins.
    always_comb
    begin
        cnt = image_count_reg;
        if (cnt < fsp_pkg::IMG_CNT_W'(1))
        begin
            cnt = fsp_pkg::IMG_CNT_W'(1);
        end
        if (cnt > fsp_pkg::IMG_CNT_W'(fsp_pkg::NUM_IMAGES))
        begin
            cnt = fsp_pkg::IMG_CNT_W'(fsp_pkg::NUM_IMAGES);
        end
        max_focus = focus[0];
        best_next = '0;
        for (int k = 1; k < fsp_pkg::NUM_IMAGES; k++)
        begin
            if ((fsp_pkg::IMG_CNT_W'(k) < cnt) && (focus[k] > max_focus))
            begin
                max_focus = focus[k];
                best_next = fsp_pkg::IDX_W'(k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            term_reg <= term_next;
            den_reg  <= den_next;
        end
    end

    // Stage 1: sum the terms and set up round(num / den) as
    // floor((2 num + den) / (2 den)).
    always_comb
    begin
        div_next = '0;
        for (int ch = 0; ch < fsp_pkg::NUM_CH; ch++)
        begin
            num_sum = '0;
            for (int k = 0; k < fsp_pkg::NUM_IMAGES; k++)
            begin
                num_sum = num_sum + fsp_pkg::NUM_W'(term_reg[k][ch]);
            end
            div_next.lane[ch].rem = (fsp_pkg::DVD_W'(num_sum) << 1)
                                    + fsp_pkg::DVD_W'(den_reg);
            div_next.lane[ch].quo = '0;
        end
        div_next.dv = fsp_pkg::DVD_W'(den_reg) << fsp_pkg::QUO_W;
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[1])
        begin
            div_word[0] <= div_next;
        end
    end

    // Side data is captured in stage 0 and follows the words through the
    // remaining stages.
    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            mode_reg[0]    <= fusion_mode_reg;
            sel_pix_reg[0] <= pix[best_next];
            sel_idx_reg[0] <= best_next;
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (stage_rdy[i])
            begin
                mode_reg[i]    <= mode_reg[i-1];
                sel_pix_reg[i] <= sel_pix_reg[i-1];
                sel_idx_reg[i] <= sel_idx_reg[i-1];
            end
        end
    end

    // Divider stages.
    for (genvar g = 0; g < fsp_pkg::DIV_STAGES; g++)
    begin : g_div
        fsp_div_stage u_div_stage
        (
            .clk  (clk),
            .en   (stage_rdy[2+g]),
            .din  (div_word[g]),
            .dout (div_word[g+1])
        );
    end

    // Output word from the last stage.
    always_comb
    begin
        m_axis_tdata = '0;
        if (mode_reg[NSTG-1] == fsp_pkg::MODE_SELECT)
        begin
            m_axis_tdata[fsp_pkg::PIX_W-1:0] = sel_pix_reg[NSTG-1];
            m_axis_tdata[fsp_pkg::PIX_W +: fsp_pkg::IDX_W] = sel_idx_reg[NSTG-1];
        end
        else
        begin
            for (int ch = 0; ch < fsp_pkg::NUM_CH; ch++)
            begin
                m_axis_tdata[ch*fsp_pkg::CH_W +: fsp_pkg::CH_W] =
                    div_word[fsp_pkg::DIV_STAGES].lane[ch].quo;
            end
        end
    end

    assign m_axis_tvalid = valid_reg[NSTG-1];

endmodule

FILE: sv/fsp_checker.sv
`timescale 1ns / 1ps
`include "focus_stack_pixel_fusion_macros.svh"

// Port-level checks of the fusion block.
module fsp_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [fsp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    // A stalled result word keeps its value.
    `FSP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

    // When the output side can move, the whole pipeline can move.
    `FSP_ASSERT_SAME(a_in_ready, clk, rst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled although the output side is free")

    // The padding above chosen_image is always zero.
    `FSP_ASSERT_SAME(a_pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[fsp_pkg::OUT_DATA_W-1:fsp_pkg::OUT_FLD_W] == '0, "output padding bits not zero")

endmodule

bind focus_stack_pixel_fusion fsp_checker u_fsp_checker (.*);

FILE: sim/focus_stack_pixel_fusion_tb.sv
`timescale 1ns / 1ps

module focus_stack_pixel_fusion_tb;

    import fsp_pkg::*;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int NUM_PHASES     = 12;
    localparam int PHASE_WORDS    = 140;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    // One fused pixel as it leaves the block.
    typedef struct packed {
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
        logic [IDX_W-1:0] chosen;
    } fused_pixel_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Testbench copy of the configuration registers.
    logic                   fusion_mode_q = MODE_WEIGHTED;
    logic [IMG_CNT_W-1:0]   image_count_q = IMAGE_COUNT_RST;

    logic [IN_DATA_W-1:0]   pixel_queue [$];
    fused_pixel_t           fused_expect [$];

    int                     send_idle_pct = 13;
    int                     recv_idle_pct = 53;
    logic                   long_hold_req = 1'b0;
    logic                   long_hold_done = 1'b0;
    int                     hold_left = 0;
    int                     mismatch_count = 0;
    int                     idle_cycles = 0;

    // Settings of the random phases: mode and raw image count.
    logic                   phase_mode  [NUM_PHASES] = '{MODE_WEIGHTED, MODE_SELECT,
        MODE_SELECT, MODE_SELECT, MODE_WEIGHTED, MODE_SELECT, MODE_SELECT, MODE_SELECT,
        MODE_WEIGHTED, MODE_SELECT, MODE_SELECT, MODE_WEIGHTED};
    logic [IMG_CNT_W-1:0]   phase_count [NUM_PHASES] = '{3'd4, 3'd1, 3'd4, 3'd0,
        3'd0, 3'd7, 3'd2, 3'd3, 3'd7, 3'd5, 3'd4, 3'd4};

    focus_stack_pixel_fusion dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // Fused pixel for one input word under the given register settings.
    function automatic fused_pixel_t fuse_pixel(input logic [IN_DATA_W-1:0] word,
                                                input logic mode,
                                                input logic [IMG_CNT_W-1:0] count);
        logic [FOCUS_W-1:0] focus  [PORT_IMAGES];
        logic [PIX_W-1:0]   colour [PORT_IMAGES];
        logic [CH_W-1:0]    chans  [NUM_CH];
        int unsigned        total;
        int unsigned        acc;
        int unsigned        chan;
        int unsigned        quot;
        int unsigned        limit;
        int unsigned        best;
        fused_pixel_t       res;
        for (int k = 0; k < PORT_IMAGES; k++)
        begin
            focus[k]  = word[k*FOCUS_W +: FOCUS_W];
            colour[k] = word[PORT_IMAGES*FOCUS_W + k*PIX_W +: PIX_W];
        end
        if (mode == MODE_WEIGHTED)
        begin
            total = 0;
            for (int k = 0; k < NUM_IMAGES; k++)
                total += 32'(focus[k]);
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                acc = 0;
                for (int k = 0; k < NUM_IMAGES; k++)
                begin
                    chan = 32'(colour[k][ch*CH_W +: CH_W]);
                    acc += (total == 0) ? chan : chan * 32'(focus[k]);
                end
                // Round half up; zero total falls back to a plain mean.
                if (total == 0)
                    quot = (2 * acc + NUM_IMAGES) / (2 * NUM_IMAGES);
                else
                    quot = (2 * acc + total) / (2 * total);
                chans[ch] = (quot > 255) ? 8'd255 : quot[7:0];
            end
            best = 0;
        end
        else
        begin
            limit = 32'(count);
            if (limit < 1)
                limit = 1;
            if (limit > NUM_IMAGES)
                limit = NUM_IMAGES;
            // Strictly greater, so the first maximum wins.
            best = 0;
            for (int k = 1; k < limit; k++)
                if (focus[k] > focus[best])
                    best = k;
            for (int ch = 0; ch < NUM_CH; ch++)
                chans[ch] = colour[best][ch*CH_W +: CH_W];
        end
        res.blue   = chans[0];
        res.green  = chans[1];
        res.red    = chans[2];
        res.chosen = best[IDX_W-1:0];
        return res;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_word(input logic [31:0] focus_set,
                                                       input logic [PIX_W-1:0] pa,
                                                       input logic [PIX_W-1:0] pb,
                                                       input logic [PIX_W-1:0] pc,
                                                       input logic [PIX_W-1:0] pd);
        return {pd, pc, pb, pa, focus_set};
    endfunction

    // Random word, shaped to hit zero totals, ties, single sharp images and extremes.
    function automatic logic [IN_DATA_W-1:0] random_word();
        logic [FOCUS_W-1:0] focus  [PORT_IMAGES];
        logic [PIX_W-1:0]   colour [PORT_IMAGES];
        logic [FOCUS_W-1:0] peak;
        int                 shape;
        int                 sharp;
        shape = $urandom_range(0, 9);
        peak  = FOCUS_W'($urandom);
        sharp = $urandom_range(0, PORT_IMAGES - 1);
        for (int k = 0; k < PORT_IMAGES; k++)
        begin
            focus[k]  = FOCUS_W'($urandom);
            colour[k] = PIX_W'($urandom);
            case (shape)
                0: focus[k] = '0;
                1: focus[k] = FOCUS_W'($urandom_range(0, 3));
                2: focus[k] = $urandom_range(0, 1) ? peak : FOCUS_W'($urandom_range(0, peak));
                3:
                begin
                    focus[k]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    colour[k] = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
                end
                4: focus[k] = (k == sharp) ? FOCUS_W'($urandom_range(1, 255)) : 8'h00;
                default: ;
            endcase
        end
        return pack_word({focus[3], focus[2], focus[1], focus[0]},
                         colour[0], colour[1], colour[2], colour[3]);
    endfunction

    // Directed words: zero totals, rounding ties, saturation edge, select ties.
    task automatic push_directed();
        pixel_queue.push_back('0);
        pixel_queue.push_back(pack_word(32'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        pixel_queue.push_back(pack_word(32'h0, 24'h010100, 24'h010000, 24'h010001, 24'h000001));
        pixel_queue.push_back(pack_word(32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                        24'hFFFFFF));
        pixel_queue.push_back(pack_word(32'hFFFFFFFF, 24'h123456, 24'hFEDCBA, 24'h00FF00,
                                        24'h80017F));
        pixel_queue.push_back(pack_word(32'h00000001, 24'hA5C3E7, 24'h000000, 24'hFFFFFF,
                                        24'h777777));
        pixel_queue.push_back(pack_word(32'hFF000000, 24'h000000, 24'h111111, 24'h222222,
                                        24'hC0FFEE));
        pixel_queue.push_back(pack_word(32'h00000101, 24'h000000, 24'h010101, 24'hFFFFFF,
                                        24'hFFFFFF));
        pixel_queue.push_back(pack_word(32'h03090905, 24'h102030, 24'h405060, 24'h708090,
                                        24'hA0B0C0));
        pixel_queue.push_back(pack_word(32'hC8000000, 24'h00FF00, 24'hFF0000, 24'h0000FF,
                                        24'h5A5A5A));
        pixel_queue.push_back({IN_DATA_W{1'b1}});
        pixel_queue.push_back({(IN_DATA_W/2){2'b10}});
        pixel_queue.push_back({(IN_DATA_W/2){2'b01}});
    endtask

    // Register write; the shadow copy follows at the accepting edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_FUSION_MODE)
            fusion_mode_q = value[0];
        else if (idx == REG_IMAGE_COUNT)
            image_count_q = value[IMG_CNT_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued word is taken and every result has come back.
    // The state is sampled at the falling edge, after the driver has settled.
    task automatic wait_for_drain();
        while (pixel_queue.size() != 0 || s_axis_tvalid || fused_expect.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_registers(input logic mode, input logic [IMG_CNT_W-1:0] count);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_FUSION_MODE, {junk[CFG_DATA_W-1:1], mode});
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_IMAGE_COUNT, {junk[CFG_DATA_W-1:IMG_CNT_W], count});
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed words in both modes, first under the reset settings.
        push_directed();
        wait_for_drain();
        set_registers(MODE_SELECT, 3'd4);
        push_directed();
        wait_for_drain();

        // Undecoded indexes must leave the settings alone.
        write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase != 0)
                set_registers(phase_mode[phase], phase_count[phase]);
            if (phase < 4)
            begin
                send_idle_pct = 13;
                recv_idle_pct = 53;
            end
            else if (phase < 8)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 13;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < PHASE_WORDS / 2; i++)
                pixel_queue.push_back(random_word());
            if (phase == 9)
                long_hold_req = 1'b1;
            // Let the pipeline run dry before the second half.
            wait_for_drain();
            for (int i = 0; i < PHASE_WORDS / 2; i++)
                pixel_queue.push_back(random_word());
            wait_for_drain();
        end

        if (mismatch_count == 0 && fused_expect.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Input driver: offers queued words, records the expectation on acceptance.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                fused_expect.push_back(fuse_pixel(s_axis_tdata, fusion_mode_q, image_count_q));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_axis_tdata  <= pixel_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string label, input logic [CH_W-1:0] want,
                               input logic [CH_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // Output monitor: compares each result word, and paces tready.
    always @(posedge clk)
    begin
        fused_pixel_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (fused_expect.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got %h", $time,
                             m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = fused_expect.pop_front();
                    check_field("fused_blue", want.blue, m_axis_tdata[7:0]);
                    check_field("fused_green", want.green, m_axis_tdata[15:8]);
                    check_field("fused_red", want.red, m_axis_tdata[23:16]);
                    check_field("chosen_image", CH_W'(want.chosen),
                                CH_W'(m_axis_tdata[25:24]));
                end
            end
            // A single long hold-off lets the pipeline fill and stall its input.
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (long_hold_req && !long_hold_done)
            begin
                hold_left <= LONG_HOLD;
                long_hold_done <= 1'b1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
